// ===== hw/rtl/bcm_pkg.sv =====
// Shared widths, types and codes for the binary confusion metrics block.
`default_nettype none

package bcm_pkg;

    // Counter and score formats
    localparam int COUNT_WIDTH     = 24;
    localparam int SCORE_FRAC_BITS = 16;
    localparam int SCORE_W         = SCORE_FRAC_BITS + 1;

    // Ratio operands: the sum of four counts, or 2tp + fp + fn
    localparam int DEN_W = COUNT_WIDTH + 2;

    // One quotient bit per divider step
    localparam int DIV_STEPS  = SCORE_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [SCORE_W-1:0] THRESHOLD_RESET = SCORE_W'(1) << (SCORE_FRAC_BITS - 1);

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] tp;
        logic [COUNT_WIDTH-1:0] tn;
        logic [COUNT_WIDTH-1:0] fp;
        logic [COUNT_WIDTH-1:0] fn;
    } bcm_counts_t;

    typedef enum logic [1:0] {
        RATIO_ACC,
        RATIO_PREC,
        RATIO_REC,
        RATIO_F1
    } bcm_ratio_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_FLUSH
    } bcm_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bcm_counters.sv =====
// Confusion counters: classify each sample and bump one saturating count.
`default_nettype none

module bcm_counters
    import bcm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic               true_label,
    input  wire logic [SCORE_W-1:0] predicted_score,
    input  wire logic               last_sample,
    input  wire logic [SCORE_W-1:0] threshold,
    output bcm_counts_t             counts_next
);

    bcm_counts_t cnt_reg;
    logic        predicted;

    // Classify the sample against the threshold
    assign predicted = predicted_score > threshold;

    // Bump exactly one count, holding at full scale
    always_comb
    begin
        counts_next = cnt_reg;
        if (true_label && predicted)
        begin
            if (!(&cnt_reg.tp))
                counts_next.tp = cnt_reg.tp + 1'b1;
        end
        else if (!true_label && !predicted)
        begin
            if (!(&cnt_reg.tn))
                counts_next.tn = cnt_reg.tn + 1'b1;
        end
        else if (!true_label && predicted)
        begin
            if (!(&cnt_reg.fp))
                counts_next.fp = cnt_reg.fp + 1'b1;
        end
        else
        begin
            if (!(&cnt_reg.fn))
                counts_next.fn = cnt_reg.fn + 1'b1;
        end
    end

    // Advance on each item, clear after the last one of a set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= last_sample ? '0 : counts_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bcm_divider.sv =====
// Bit-serial restoring divider: floor(num * 2^SCORE_FRAC_BITS / den), num <= den.
`default_nettype none

module bcm_divider
    import bcm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DEN_W-1:0]   num,
    input  wire logic [DEN_W-1:0]   den,
    output logic                    done,
    output logic [SCORE_W-1:0]      quot
);

    logic [DEN_W:0]         rem_reg;
    logic [DEN_W:0]         rem_next;
    logic [DEN_W-1:0]       den_reg;
    logic [SCORE_W-1:0]     quot_reg;
    logic [STEP_CNT_W-1:0]  cnt_reg;
    logic                   active_reg;
    logic                   done_reg;
    logic                   den_zero_reg;
    logic                   ge;
    logic [DEN_W:0]         diff;
    logic [DEN_W:0]         rem_sel;

    // Trial subtract for one quotient bit
    assign ge       = rem_reg >= {1'b0, den_reg};
    assign diff     = rem_reg - {1'b0, den_reg};
    assign rem_sel  = ge ? diff : rem_reg;
    assign rem_next = {rem_sel[DEN_W-1:0], 1'b0};

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= STEP_CNT_W'(DIV_STEPS);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= {1'b0, num};
            den_reg      <= den;
            den_zero_reg <= (den == '0);
            quot_reg     <= '0;
        end
        else if (active_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[SCORE_W-2:0], ge};
        end
    end

    // Zero denominator gives a zero ratio
    assign done = done_reg;
    assign quot = den_zero_reg ? '0 : quot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_confusion_metrics.sv =====
// Binary confusion metrics: four saturating counts plus accuracy, precision, recall, F1.
// Each accepted item is counted; non-last items stream at 1 per cycle. A last item's
// result comes from four ratios run in turn on one shared bit-serial divider
// (17 quotient bits), then an output load that waits until the output is free.
// Non-last items of the next set are taken during that time; the next last item waits.
// Reset clears the counts and output valid and sets the threshold to 0.5.
`default_nettype none

module binary_confusion_metrics
    import bcm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   decision_threshold_we,
    input  wire logic [SCORE_W-1:0]     decision_threshold,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   true_label,
    input  wire logic [SCORE_W-1:0]     predicted_score,
    input  wire logic                   last_sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [COUNT_WIDTH-1:0]      true_pos_count,
    output logic [COUNT_WIDTH-1:0]      true_neg_count,
    output logic [COUNT_WIDTH-1:0]      false_pos_count,
    output logic [COUNT_WIDTH-1:0]      false_neg_count,
    output logic [SCORE_W-1:0]          accuracy_ratio,
    output logic [SCORE_W-1:0]          precision_ratio,
    output logic [SCORE_W-1:0]          recall_ratio,
    output logic [SCORE_W-1:0]          f1_ratio
);

    bcm_state_t         state_reg, state_next;
    bcm_ratio_t         sel_reg, sel_next;
    logic [SCORE_W-1:0] thr_reg;
    bcm_counts_t        counts_next;
    bcm_counts_t        snap_reg;
    logic [SCORE_W-1:0] acc_reg, prec_reg, rec_reg, f1_reg;
    logic               out_valid_reg;
    logic               accept;
    logic               snap_load;
    logic               div_start;
    logic               div_done;
    logic [SCORE_W-1:0] div_quot;
    logic               ratio_we;
    logic               out_load;
    logic [DEN_W-1:0]   tp_e, tn_e, fp_e, fn_e;
    logic [DEN_W-1:0]   div_num, div_den;

    // Hold off a last item until the ratio engine is free
    assign in_ready  = (state_reg == ST_IDLE) || !last_sample;
    assign accept    = in_valid && in_ready;
    assign snap_load = accept && last_sample;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESHOLD_RESET;
        else if (decision_threshold_we)
            thr_reg <= decision_threshold;
    end

    bcm_counters u_counters (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .true_label      (true_label),
        .predicted_score (predicted_score),
        .last_sample     (last_sample),
        .threshold       (thr_reg),
        .counts_next     (counts_next)
    );

    // Capture the final counts of a set
    always_ff @(posedge clk)
    begin
        if (snap_load)
            snap_reg <= counts_next;
    end

    // Select numerator and denominator for the current ratio
    assign tp_e = {2'b00, snap_reg.tp};
    assign tn_e = {2'b00, snap_reg.tn};
    assign fp_e = {2'b00, snap_reg.fp};
    assign fn_e = {2'b00, snap_reg.fn};

    always_comb
    begin
        div_num = '0;
        div_den = '0;
        unique case (sel_reg)
            RATIO_ACC:
            begin
                div_num = tp_e + tn_e;
                div_den = (tp_e + tn_e) + (fp_e + fn_e);
            end
            RATIO_PREC:
            begin
                div_num = tp_e;
                div_den = tp_e + fp_e;
            end
            RATIO_REC:
            begin
                div_num = tp_e;
                div_den = tp_e + fn_e;
            end
            RATIO_F1:
            begin
                div_num = {tp_e[DEN_W-2:0], 1'b0};
                div_den = {tp_e[DEN_W-2:0], 1'b0} + (fp_e + fn_e);
            end
        endcase
    end

    bcm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= RATIO_ACC;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Sequencer: run the four ratios through the divider, then load the output
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        div_start  = 1'b0;
        ratio_we   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (snap_load)
                begin
                    state_next = ST_START;
                    sel_next   = RATIO_ACC;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    ratio_we = 1'b1;
                    unique case (sel_reg)
                        RATIO_ACC:
                        begin
                            sel_next   = RATIO_PREC;
                            state_next = ST_START;
                        end
                        RATIO_PREC:
                        begin
                            sel_next   = RATIO_REC;
                            state_next = ST_START;
                        end
                        RATIO_REC:
                        begin
                            sel_next   = RATIO_F1;
                            state_next = ST_START;
                        end
                        RATIO_F1:
                        begin
                            sel_next   = RATIO_ACC;
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Store each finished ratio
    always_ff @(posedge clk)
    begin
        if (ratio_we)
        begin
            unique case (sel_reg)
                RATIO_ACC:  acc_reg  <= div_quot;
                RATIO_PREC: prec_reg <= div_quot;
                RATIO_REC:  rec_reg  <= div_quot;
                RATIO_F1:   f1_reg   <= div_quot;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            true_pos_count  <= snap_reg.tp;
            true_neg_count  <= snap_reg.tn;
            false_pos_count <= snap_reg.fp;
            false_neg_count <= snap_reg.fn;
            accuracy_ratio  <= acc_reg;
            precision_ratio <= prec_reg;
            recall_ratio    <= rec_reg;
            f1_ratio        <= f1_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the binary confusion metrics block.
`timescale 1ns / 1ps

module tb_top;
    import bcm_pkg::*;

    localparam int SCORE_MAX      = (1 << SCORE_W) - 1;
    localparam int SCORE_ONE      = 1 << SCORE_FRAC_BITS;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 72;

    typedef struct {
        logic               label;
        logic [SCORE_W-1:0] score;
        logic               last;
        bit                 drain_before;
    } sample_t;

    typedef struct {
        bcm_counts_t        counts;
        logic [SCORE_W-1:0] accuracy;
        logic [SCORE_W-1:0] precision;
        logic [SCORE_W-1:0] recall;
        logic [SCORE_W-1:0] f1;
    } metrics_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   decision_threshold_we = 1'b0;
    logic [SCORE_W-1:0]     decision_threshold = THRESHOLD_RESET;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   true_label = 1'b0;
    logic [SCORE_W-1:0]     predicted_score = '0;
    logic                   last_sample = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [COUNT_WIDTH-1:0] true_pos_count;
    logic [COUNT_WIDTH-1:0] true_neg_count;
    logic [COUNT_WIDTH-1:0] false_pos_count;
    logic [COUNT_WIDTH-1:0] false_neg_count;
    logic [SCORE_W-1:0]     accuracy_ratio;
    logic [SCORE_W-1:0]     precision_ratio;
    logic [SCORE_W-1:0]     recall_ratio;
    logic [SCORE_W-1:0]     f1_ratio;

    // Predictor state and scoreboard
    logic [SCORE_W-1:0] threshold_model = THRESHOLD_RESET;
    bcm_counts_t        tally = '0;
    sample_t            sample_queue[$];
    metrics_t           expected_metrics[$];
    sample_t            launch_sample;
    int unsigned        error_count = 0;
    int unsigned        result_index = 0;
    int unsigned        send_gap = 0;
    int unsigned        recv_stall = 0;
    int unsigned        quiet_cycles = 0;
    bit                 steady_send = 1'b0;
    bit                 steady_recv = 1'b0;

    binary_confusion_metrics uut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .decision_threshold_we (decision_threshold_we),
        .decision_threshold    (decision_threshold),
        .in_valid              (in_valid),
        .in_ready              (in_ready),
        .true_label            (true_label),
        .predicted_score       (predicted_score),
        .last_sample           (last_sample),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .true_pos_count        (true_pos_count),
        .true_neg_count        (true_neg_count),
        .false_pos_count       (false_pos_count),
        .false_neg_count       (false_neg_count),
        .accuracy_ratio        (accuracy_ratio),
        .precision_ratio       (precision_ratio),
        .recall_ratio          (recall_ratio),
        .f1_ratio              (f1_ratio)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [COUNT_WIDTH-1:0] sat_bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Truncated Q1.16 quotient; a zero denominator gives zero
    function automatic logic [SCORE_W-1:0] q16_ratio(input longint unsigned num,
                                                     input longint unsigned den);
        if (den == 0)
            return '0;
        return SCORE_W'((num << SCORE_FRAC_BITS) / den);
    endfunction

    // Count one accepted sample; on the last one queue the set's metrics and clear
    function automatic void absorb_sample(input logic label, input logic [SCORE_W-1:0] score,
                                          input logic last);
        logic             positive;
        metrics_t         m;
        longint unsigned  tp, tn, fp, fn;
        positive = score > threshold_model;
        if (label && positive)
            tally.tp = sat_bump(tally.tp);
        else if (!label && !positive)
            tally.tn = sat_bump(tally.tn);
        else if (!label && positive)
            tally.fp = sat_bump(tally.fp);
        else
            tally.fn = sat_bump(tally.fn);
        if (last)
        begin
            tp = 64'(tally.tp);
            tn = 64'(tally.tn);
            fp = 64'(tally.fp);
            fn = 64'(tally.fn);
            m.counts    = tally;
            m.accuracy  = q16_ratio(tp + tn, tp + tn + fp + fn);
            m.precision = q16_ratio(tp, tp + fp);
            m.recall    = q16_ratio(tp, tp + fn);
            m.f1        = q16_ratio(2 * tp, 2 * tp + fp + fn);
            expected_metrics.push_back(m);
            tally = '0;
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_idle(input bit steady);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Scores cluster on the threshold and the ends of the range
    function automatic logic [SCORE_W-1:0] pick_score();
        int unsigned roll;
        int          near;
        roll = $urandom_range(0, 99);
        near = int'(threshold_model) + int'($urandom_range(0, 2)) - 1;
        if (near < 0)
            near = 0;
        if (near > SCORE_MAX)
            near = SCORE_MAX;
        if (roll < 50)
            return SCORE_W'($urandom_range(0, SCORE_ONE));
        if (roll < 65)
            return SCORE_W'(near);
        if (roll < 72)
            return '0;
        if (roll < 79)
            return SCORE_W'(SCORE_ONE);
        if (roll < 85)
            return SCORE_W'($urandom_range(SCORE_ONE + 1, SCORE_MAX));
        return SCORE_W'($urandom_range(0, SCORE_MAX));
    endfunction

    task automatic push_sample(input logic label, input int score, input logic last,
                               input bit drain_before);
        sample_t s;
        s.label        = label;
        s.score        = SCORE_W'(score);
        s.last         = last;
        s.drain_before = drain_before;
        sample_queue.push_back(s);
    endtask

    // Queue whole sets of random length until the item budget is spent
    task automatic queue_random_sets(input int unsigned budget);
        int unsigned queued;
        int unsigned len;
        int unsigned roll;
        queued = 0;
        while (queued < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                len = $urandom_range(1, 6);
            else if (roll < 95)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(21, 80);
            for (int unsigned i = 0; i < len; i++)
                push_sample(1'($urandom_range(0, 1)), int'(pick_score()), i == len - 1,
                            i == 0 && $urandom_range(0, 19) == 0);
            queued += len;
        end
    endtask

    // Wait until nothing is queued, driven or outstanding, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || expected_metrics.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input int value);
        wait_idle();
        decision_threshold    <= SCORE_W'(value);
        decision_threshold_we <= 1'b1;
        @(posedge clk);
        decision_threshold_we <= 1'b0;
        threshold_model = SCORE_W'(value);
    endtask

    task automatic check_field(input string field, input logic [COUNT_WIDTH-1:0] got,
                               input logic [COUNT_WIDTH-1:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s = %0d, expected %0d",
                                   result_index, field, got, want));
    endtask

    task automatic check_result();
        metrics_t want;
        if (expected_metrics.size() == 0)
        begin
            report_error($sformatf("result with no set pending: tp=%0d tn=%0d fp=%0d fn=%0d",
                                   true_pos_count, true_neg_count, false_pos_count,
                                   false_neg_count));
            return;
        end
        want = expected_metrics.pop_front();
        check_field("true_pos_count", true_pos_count, want.counts.tp);
        check_field("true_neg_count", true_neg_count, want.counts.tn);
        check_field("false_pos_count", false_pos_count, want.counts.fp);
        check_field("false_neg_count", false_neg_count, want.counts.fn);
        check_field("accuracy_ratio", COUNT_WIDTH'(accuracy_ratio),
                    COUNT_WIDTH'(want.accuracy));
        check_field("precision_ratio", COUNT_WIDTH'(precision_ratio),
                    COUNT_WIDTH'(want.precision));
        check_field("recall_ratio", COUNT_WIDTH'(recall_ratio),
                    COUNT_WIDTH'(want.recall));
        check_field("f1_ratio", COUNT_WIDTH'(f1_ratio), COUNT_WIDTH'(want.f1));
        result_index++;
    endtask

    // Sender: predict on acceptance, then launch the next item after its gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_sample(true_label, predicted_score, last_sample);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0 &&
                         !(sample_queue[0].drain_before && expected_metrics.size() != 0))
                begin
                    launch_sample = sample_queue.pop_front();
                    true_label      <= launch_sample.label;
                    predicted_score <= launch_sample.score;
                    last_sample     <= launch_sample.last;
                    in_valid        <= 1'b1;
                    send_gap = pick_idle(steady_send);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (recv_stall != 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_idle(steady_recv);
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset threshold of one half: pure and mixed sets, ties, overrange scores
        push_sample(1'b1, SCORE_ONE, 1'b1, 1'b0);
        push_sample(1'b0, 0, 1'b1, 1'b0);
        push_sample(1'b1, 32768, 1'b0, 1'b0);
        push_sample(1'b0, 32769, 1'b1, 1'b0);
        push_sample(1'b0, SCORE_MAX, 1'b1, 1'b0);
        push_sample(1'b1, 40000, 1'b0, 1'b1);
        push_sample(1'b0, 100, 1'b0, 1'b0);
        push_sample(1'b0, 50000, 1'b0, 1'b0);
        push_sample(1'b1, 1000, 1'b1, 1'b0);
        push_sample(1'b1, 32767, 1'b1, 1'b0);

        // Threshold of one: only overrange scores count as positive
        write_threshold(SCORE_ONE);
        push_sample(1'b1, SCORE_ONE, 1'b0, 1'b0);
        push_sample(1'b1, SCORE_ONE + 1, 1'b1, 1'b0);

        // Threshold of zero: any nonzero score is positive
        write_threshold(0);
        push_sample(1'b0, 0, 1'b0, 1'b0);
        push_sample(1'b1, 1, 1'b1, 1'b0);

        // Largest register value: nothing is positive
        write_threshold(SCORE_MAX);
        push_sample(1'b1, SCORE_MAX, 1'b1, 1'b0);
        push_sample(1'b0, SCORE_MAX, 1'b1, 1'b0);

        // Random sets under a sweep of thresholds
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: write_threshold($urandom_range(1, SCORE_ONE - 1));
                1: write_threshold(0);
                2: write_threshold(SCORE_ONE);
                3: write_threshold(SCORE_MAX);
                4: write_threshold(int'(THRESHOLD_RESET));
                5: write_threshold($urandom_range(0, SCORE_MAX));
                default: write_threshold(1);
            endcase
            steady_send = ($urandom_range(0, 3) == 0);
            steady_recv = ($urandom_range(0, 3) == 0);
            queue_random_sets(PHASE_ITEMS);
        end

        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bcm_pkg.sv
hw/rtl/bcm_counters.sv
hw/rtl/bcm_divider.sv
hw/rtl/binary_confusion_metrics.sv
verif/tb_top.sv
